// ===== rtl/tcps_pkg.sv =====
// ----------------------------------------------------------------------------
// tcps_pkg: shared types, constants and color functions
// Palette, byte order, channel blend and box-drawing flags used by the
// stages of the terminal cell pixel shader.
// ----------------------------------------------------------------------------
package tcps_pkg;

  // configuration register indexes (byte address 4*index)
  localparam int          CFG_ADDR_W          = 4;
  localparam logic [1:0]  REG_CELL_WIDTH      = 2'd0;
  localparam logic [1:0]  REG_CELL_HEIGHT     = 2'd1;
  localparam logic [1:0]  REG_BLUE_RED_SWAP   = 2'd2;
  localparam logic [1:0]  REG_CURSOR_INDEX    = 2'd3;

  localparam logic [5:0]  RESET_CELL_WIDTH    = 6'd8;
  localparam logic [6:0]  RESET_CELL_HEIGHT   = 7'd16;
  localparam logic [7:0]  RESET_CURSOR_INDEX  = 8'd15;

  // code point ranges
  localparam logic [20:0] CODE_SPACE          = 21'h000020;
  localparam logic [20:0] CODE_BOM            = 21'h00FEFF;
  localparam logic [20:0] BRAILLE_BASE        = 21'h002800;
  localparam logic [20:0] BOX_BASE            = 21'h002500;
  localparam logic [20:0] BOX_H_LAST          = 21'h002501;
  localparam logic [20:0] BOX_V_LAST          = 21'h002503;
  localparam logic [20:0] BOX_TAB_BASE        = 21'h00250C;
  localparam logic [6:0]  BOX_TAB_LEN         = 7'd64;
  localparam logic [20:0] BLOCK_BASE          = 21'h002580;
  localparam logic [20:0] BLOCK_FULL          = 21'h002588;

  // box segment flags: bit0 left, bit1 right, bit2 up, bit3 down
  localparam logic [3:0]  BOX_HLINE           = 4'd3;
  localparam logic [3:0]  BOX_VLINE           = 4'd12;

  localparam logic [7:0]  DIM_ALPHA           = 8'd128;

  typedef enum logic [2:0] {
    SHAPE_NONE,
    SHAPE_BRAILLE,
    SHAPE_BOX,
    SHAPE_BLOCK,
    SHAPE_GLYPH
  } shape_e;

  // configuration as seen by the datapath, geometry already saturated
  typedef struct packed {
    logic [5:0] cell_width;
    logic [6:0] cell_height;
    logic       blue_red_swapped;
    logic [7:0] cursor_color_index;
  } cfg_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic        fore_is_rgb;
    logic [23:0] fore_value;
    logic        back_is_rgb;
    logic [23:0] back_value;
    logic [3:0]  attr_flags;
    logic        double_wide;
    logic        cursor_here;
    logic [5:0]  pixel_x;
    logic [5:0]  pixel_y;
    logic [7:0]  glyph_alpha;
  } item_t;

  // decode stage result
  typedef struct packed {
    logic [23:0] fg;
    logic [23:0] bg;
    logic [23:0] cur_rgb;
    logic        dim;
    logic        uline;
    logic        cursor_here;
    logic        double_wide;
    shape_e      shape;
    logic [7:0]  sel;
    logic [6:0]  ys;
    logic [6:0]  ye;
    logic [7:0]  alpha;
    logic [5:0]  x;
    logic [5:0]  y;
  } dec_t;

  // shape stage result
  typedef struct packed {
    logic [23:0] fg;
    logic [23:0] bg;
    logic [23:0] cur_rgb;
    logic [7:0]  alpha;
    logic        glyph;
    logic        hit;
    logic        uline_hit;
    logic        cursor_hit;
  } shp_t;

  function automatic logic [7:0] cube_level(input logic [2:0] n);
    logic [7:0] v;
    v = 8'(8'(n) * 8'd40 + 8'd55);
    return (n == 3'd0) ? 8'd0 : v;
  endfunction

  function automatic logic [23:0] pal_rgb(input logic [7:0] i);
    logic [7:0] v;
    logic [7:0] k;
    logic [7:0] r;
    logic [2:0] q36;
    logic [2:0] q6;
    logic [2:0] m6;
    logic [23:0] rgb;
    v   = '0;
    k   = '0;
    r   = '0;
    q36 = '0;
    q6  = '0;
    m6  = '0;
    rgb = '0;
    if (i < 8'd16) begin
      v = i[3] ? 8'hFF : 8'hAA;
      rgb = {i[0] ? v : 8'h00, i[1] ? v : 8'h00, i[2] ? v : 8'h00};
      if (i == 8'd0) rgb = 24'h000000;
      if (i == 8'd7) rgb = 24'hC0C0C0;
      if (i == 8'd8) rgb = 24'h555555;
    end else if (i < 8'd232) begin
      k = i - 8'd16;
      q36 = (k >= 8'd180) ? 3'd5 : (k >= 8'd144) ? 3'd4 : (k >= 8'd108) ? 3'd3 :
            (k >= 8'd72)  ? 3'd2 : (k >= 8'd36)  ? 3'd1 : 3'd0;
      r = k - 8'(8'(q36) * 8'd36);
      q6 = (r >= 8'd30) ? 3'd5 : (r >= 8'd24) ? 3'd4 : (r >= 8'd18) ? 3'd3 :
           (r >= 8'd12) ? 3'd2 : (r >= 8'd6)  ? 3'd1 : 3'd0;
      m6 = 3'(r - 8'(8'(q6) * 8'd6));
      rgb = {cube_level(q36), cube_level(q6), cube_level(m6)};
    end else begin
      v = 8'(8'(i - 8'd232) * 8'd10 + 8'd8);
      rgb = {v, v, v};
    end
    return rgb;
  endfunction

  function automatic logic [23:0] put_order(input logic [23:0] rgb, input logic swap);
    return swap ? {rgb[7:0], rgb[15:8], rgb[23:16]} : rgb;
  endfunction

  // flags for the box codes starting at the first corner
  function automatic logic [3:0] box_segs(input logic [5:0] o);
    logic [3:0] f;
    case (o[5:4])
      2'd0: begin
        case (o[3:2])
          2'd0:    f = 4'd10;
          2'd1:    f = 4'd9;
          2'd2:    f = 4'd6;
          default: f = 4'd5;
        endcase
      end
      2'd1:    f = o[3] ? 4'd13 : 4'd14;
      2'd2:    f = o[3] ? 4'd7 : 4'd11;
      default: f = 4'd15;
    endcase
    return f;
  endfunction

  function automatic logic [7:0] mix_chan(input logic [7:0] b, input logic [7:0] f,
                                          input logic [7:0] a);
    logic [15:0] s;
    s = 16'(16'(f) * 16'(a)) + 16'(16'(b) * 16'(8'hFF - a));
    return s[15:8];
  endfunction

  function automatic logic [23:0] mix_rgb(input logic [23:0] bg, input logic [23:0] fg,
                                          input logic [7:0] a);
    logic [23:0] m;
    m = {mix_chan(bg[23:16], fg[23:16], a), mix_chan(bg[15:8], fg[15:8], a),
         mix_chan(bg[7:0], fg[7:0], a)};
    if (a == 8'h00) m = bg;
    if (a == 8'hFF) m = fg;
    return m;
  endfunction

endpackage

// ===== rtl/tcps_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tcps_cfg_regs: configuration register file
// APB-style write/read of the four registers; presents saturated geometry.
// ----------------------------------------------------------------------------
module tcps_cfg_regs #(
  parameter int MAX_CELL_WIDTH  = 32,
  parameter int MAX_CELL_HEIGHT = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tcps_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output tcps_pkg::cfg_t                  cfg_o
);
  import tcps_pkg::*;

  localparam int CW_CAP = (MAX_CELL_WIDTH > 63) ? 63 : MAX_CELL_WIDTH;
  localparam int CH_CAP = (MAX_CELL_HEIGHT > 127) ? 127 : MAX_CELL_HEIGHT;

  logic [5:0] cell_width_q;
  logic [6:0] cell_height_q;
  logic       swap_q;
  logic [7:0] cursor_idx_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_width_q  <= RESET_CELL_WIDTH;
      cell_height_q <= RESET_CELL_HEIGHT;
      swap_q        <= 1'b0;
      cursor_idx_q  <= RESET_CURSOR_INDEX;
    end else if (wr_en) begin
      case (reg_idx)
        REG_CELL_WIDTH:    cell_width_q  <= pwdata[5:0];
        REG_CELL_HEIGHT:   cell_height_q <= pwdata[6:0];
        REG_BLUE_RED_SWAP: swap_q        <= pwdata[0];
        REG_CURSOR_INDEX:  cursor_idx_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CELL_WIDTH:    prdata = {26'd0, cell_width_q};
      REG_CELL_HEIGHT:   prdata = {25'd0, cell_height_q};
      REG_BLUE_RED_SWAP: prdata = {31'd0, swap_q};
      REG_CURSOR_INDEX:  prdata = {24'd0, cursor_idx_q};
      default:           prdata = '0;
    endcase
  end

  // clamp geometry into the supported range
  always_comb begin
    cfg_o.cell_width = cell_width_q;
    if (cell_width_q == 6'd0) cfg_o.cell_width = 6'd1;
    else if (32'(cell_width_q) > 32'(CW_CAP)) cfg_o.cell_width = 6'(CW_CAP);
    cfg_o.cell_height = cell_height_q;
    if (cell_height_q == 7'd0) cfg_o.cell_height = 7'd1;
    else if (32'(cell_height_q) > 32'(CH_CAP)) cfg_o.cell_height = 7'(CH_CAP);
    cfg_o.blue_red_swapped   = swap_q;
    cfg_o.cursor_color_index = cursor_idx_q;
  end

endmodule

// ===== rtl/tcps_decode.sv =====
// ----------------------------------------------------------------------------
// tcps_decode: first pipeline stage
// Resolves palette colors, reverse and bold, classifies the code point and
// works out the block-element row span.
// ----------------------------------------------------------------------------
module tcps_decode (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tcps_pkg::cfg_t  cfg_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tcps_pkg::item_t in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output tcps_pkg::dec_t  out_data_o
);
  import tcps_pkg::*;

  logic        valid_q;
  dec_t        data_q;
  dec_t        data_d;
  logic        load;
  logic [23:0] fg0;
  logic [23:0] bg0;
  logic [23:0] bold_rgb;
  logic        bold;
  logic [20:0] code;
  logic [6:0]  lo;
  logic [6:0]  ch;
  logic [6:0]  fh;
  logic [3:0]  bk;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign load        = in_valid_i && in_ready_o;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_comb begin
    code = in_data_i.code_point;
    lo   = code[6:0];
    ch   = cfg_i.cell_height;
    bk   = code[3:0] - BLOCK_BASE[3:0];
    fh   = 7'((10'(ch) * 10'(bk[2:0])) >> 3);

    fg0 = put_order(in_data_i.fore_is_rgb ? in_data_i.fore_value :
                    pal_rgb(in_data_i.fore_value[7:0]), cfg_i.blue_red_swapped);
    bg0 = put_order(in_data_i.back_is_rgb ? in_data_i.back_value :
                    pal_rgb(in_data_i.back_value[7:0]), cfg_i.blue_red_swapped);
    // bold brightens by the original index, ignoring reverse
    bold_rgb = put_order(pal_rgb({4'b0000, 1'b1, in_data_i.fore_value[2:0]}),
                         cfg_i.blue_red_swapped);
    bold = in_data_i.attr_flags[1] && !in_data_i.fore_is_rgb &&
           (in_data_i.fore_value[7:0] < 8'd8);

    data_d.fg = bold ? bold_rgb : (in_data_i.attr_flags[0] ? bg0 : fg0);
    data_d.bg = in_data_i.attr_flags[0] ? fg0 : bg0;
    data_d.cur_rgb = put_order(pal_rgb(cfg_i.cursor_color_index), cfg_i.blue_red_swapped);
    data_d.dim = in_data_i.attr_flags[2] && !in_data_i.attr_flags[0];
    data_d.uline = in_data_i.attr_flags[3];
    data_d.cursor_here = in_data_i.cursor_here;
    data_d.double_wide = in_data_i.double_wide;
    data_d.alpha = in_data_i.glyph_alpha;
    data_d.x = in_data_i.pixel_x;
    data_d.y = in_data_i.pixel_y;
    data_d.sel = '0;
    data_d.ys = '0;
    data_d.ye = ch;

    if (code <= CODE_SPACE || code == CODE_BOM) begin
      data_d.shape = SHAPE_NONE;
    end else if (code[20:8] == BRAILLE_BASE[20:8]) begin
      data_d.shape = SHAPE_BRAILLE;
      data_d.sel = code[7:0];
    end else if (code[20:7] == BOX_BASE[20:7]) begin
      data_d.shape = SHAPE_BOX;
      if (lo <= BOX_H_LAST[6:0]) data_d.sel = {4'd0, BOX_HLINE};
      else if (lo <= BOX_V_LAST[6:0]) data_d.sel = {4'd0, BOX_VLINE};
      else if (lo >= BOX_TAB_BASE[6:0] && lo < BOX_TAB_BASE[6:0] + BOX_TAB_LEN)
        data_d.sel = {4'd0, box_segs(6'(lo - BOX_TAB_BASE[6:0]))};
      else data_d.sel = {4'd0, BOX_HLINE};
    end else if (code >= BLOCK_BASE && code <= BLOCK_FULL) begin
      data_d.shape = SHAPE_BLOCK;
      // upper half spans the top rows, the eighths grow up from the bottom
      if (code == BLOCK_BASE) data_d.ye = {1'b0, ch[6:1]};
      else if (code != BLOCK_FULL) data_d.ys = ch - fh;
    end else begin
      data_d.shape = SHAPE_GLYPH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== rtl/tcps_shape.sv =====
// ----------------------------------------------------------------------------
// tcps_shape: second pipeline stage
// Applies dim, tests the pixel against braille dots, box lines and block
// rows, and evaluates the underline and cursor areas.
// ----------------------------------------------------------------------------
module tcps_shape (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tcps_pkg::cfg_t cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tcps_pkg::dec_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tcps_pkg::shp_t out_data_o
);
  import tcps_pkg::*;

  localparam int DOT_BIT [2][4] = '{'{0, 1, 2, 6}, '{3, 4, 5, 7}};

  logic       valid_q;
  shp_t       data_q;
  shp_t       data_d;
  logic       load;
  logic [6:0] pw;
  logic [6:0] ch;
  logic [5:0] cw;
  logic [5:0] dw;
  logic [4:0] dh;
  logic [4:0] dotw;
  logic [3:0] doth;
  logic [5:0] mx;
  logic [5:0] my;
  logic [7:0] xe;
  logic [7:0] ye;
  logic [7:0] dx [2];
  logic [7:0] dy [4];
  logic       braille_hit;
  logic       box_hit;
  logic       block_hit;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign load        = in_valid_i && in_ready_o;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_comb begin
    cw   = cfg_i.cell_width;
    ch   = cfg_i.cell_height;
    pw   = in_data_i.double_wide ? {cw, 1'b0} : {1'b0, cw};
    dw   = pw[6:1];
    dh   = ch[6:2];
    dotw = (dw[5:1] == 5'd0) ? 5'd1 : dw[5:1];
    doth = (dh[4:1] == 4'd0) ? 4'd1 : dh[4:1];
    mx   = pw[6:1];
    my   = ch[6:1];
    xe   = {2'b00, in_data_i.x};
    ye   = {2'b00, in_data_i.y};

    // dot origins sit a quarter pitch into each column and row
    dx[0] = {4'd0, dw[5:2]};
    dx[1] = {2'b00, dw} + {4'd0, dw[5:2]};
    for (int r = 0; r < 4; r++) begin
      dy[r] = 8'(8'(r) * {3'b000, dh}) + {5'd0, dh[4:2]};
    end

    braille_hit = 1'b0;
    for (int c = 0; c < 2; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (in_data_i.sel[DOT_BIT[c][r]] &&
            xe >= dx[c] && xe < dx[c] + {3'd0, dotw} &&
            ye >= dy[r] && ye < dy[r] + {4'd0, doth})
          braille_hit = 1'b1;
      end
    end

    box_hit = (in_data_i.sel[0] && in_data_i.y == my && in_data_i.x <= mx) ||
              (in_data_i.sel[1] && in_data_i.y == my && in_data_i.x >= mx &&
               {1'b0, in_data_i.x} < pw) ||
              (in_data_i.sel[2] && in_data_i.x == mx && in_data_i.y <= my) ||
              (in_data_i.sel[3] && in_data_i.x == mx && in_data_i.y >= my &&
               {1'b0, in_data_i.y} < ch);

    block_hit = {1'b0, in_data_i.x} < pw && {1'b0, in_data_i.y} >= in_data_i.ys &&
                {1'b0, in_data_i.y} < in_data_i.ye;

    data_d.fg = in_data_i.dim ? mix_rgb(in_data_i.bg, in_data_i.fg, DIM_ALPHA)
                              : in_data_i.fg;
    data_d.bg = in_data_i.bg;
    data_d.cur_rgb = in_data_i.cur_rgb;
    data_d.alpha = in_data_i.alpha;
    data_d.glyph = (in_data_i.shape == SHAPE_GLYPH);
    case (in_data_i.shape)
      SHAPE_BRAILLE: data_d.hit = braille_hit;
      SHAPE_BOX:     data_d.hit = box_hit;
      SHAPE_BLOCK:   data_d.hit = block_hit;
      default:       data_d.hit = 1'b0;
    endcase
    // second row from the bottom; never matches when the cell is one row high
    data_d.uline_hit = in_data_i.uline && {1'b0, in_data_i.x} < pw &&
                       ({1'b0, in_data_i.y} + 7'd2 == ch);
    data_d.cursor_hit = in_data_i.cursor_here && in_data_i.x < cw &&
                        {1'b0, in_data_i.y} < ch;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== rtl/tcps_blend.sv =====
// ----------------------------------------------------------------------------
// tcps_blend: last pipeline stage and output register
// Blends glyph coverage and composes shape, underline and cursor.
// ----------------------------------------------------------------------------
module tcps_blend (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tcps_pkg::shp_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [23:0]    pixel_color_o
);
  import tcps_pkg::*;

  logic        valid_q;
  logic [23:0] pixel_q;
  logic [23:0] pixel_d;
  logic        load;

  assign in_ready_o    = !valid_q || out_ready_i;
  assign load          = in_valid_i && in_ready_o;
  assign out_valid_o   = valid_q;
  assign pixel_color_o = pixel_q;

  always_comb begin
    if (in_data_i.glyph) pixel_d = mix_rgb(in_data_i.bg, in_data_i.fg, in_data_i.alpha);
    else if (in_data_i.hit) pixel_d = in_data_i.fg;
    else pixel_d = in_data_i.bg;
    if (in_data_i.uline_hit) pixel_d = in_data_i.fg;
    if (in_data_i.cursor_hit) pixel_d = in_data_i.cur_rgb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pixel_q <= pixel_d;
    end
  end

endmodule

// ===== rtl/terminal_cell_pixel_shader_unit.sv =====
// ----------------------------------------------------------------------------
// terminal_cell_pixel_shader_unit: character cell pixel shader
// Gives the 24-bit color of one pixel of a text-mode character cell.
// ----------------------------------------------------------------------------
// channel  dir  handshake                 payload
// in       in   in_valid_i / in_ready_o   code_point_i .. glyph_alpha_i
// out      out  out_valid_o / out_ready_i pixel_color_o
// cfg      in   psel, penable, pwrite     paddr, pwdata / prdata, pready
//
// one pixel per clock while out_ready_i is high; a pixel passes the decode,
// shape and blend register stages, the last of which is the output register
// reset clears the stage valid bits and loads the register defaults
// a low out_ready_i holds the output; each stage still fills while its
// successor is full, so bubbles close up and nothing is lost or repeated
// ----------------------------------------------------------------------------
module terminal_cell_pixel_shader_unit #(
  parameter int MAX_CELL_WIDTH  = 32,
  parameter int MAX_CELL_HEIGHT = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tcps_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [20:0]                     code_point_i,
  input  logic                            fore_is_rgb_i,
  input  logic [23:0]                     fore_value_i,
  input  logic                            back_is_rgb_i,
  input  logic [23:0]                     back_value_i,
  input  logic [3:0]                      attr_flags_i,
  input  logic                            double_wide_i,
  input  logic                            cursor_here_i,
  input  logic [5:0]                      pixel_x_i,
  input  logic [5:0]                      pixel_y_i,
  input  logic [7:0]                      glyph_alpha_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [23:0]                     pixel_color_o
);
  import tcps_pkg::*;

  cfg_t  cfg;
  item_t item;
  dec_t  dec_data;
  shp_t  shp_data;
  logic  dec_valid;
  logic  dec_ready;
  logic  shp_valid;
  logic  shp_ready;

  assign item = '{
    code_point:  code_point_i,
    fore_is_rgb: fore_is_rgb_i,
    fore_value:  fore_value_i,
    back_is_rgb: back_is_rgb_i,
    back_value:  back_value_i,
    attr_flags:  attr_flags_i,
    double_wide: double_wide_i,
    cursor_here: cursor_here_i,
    pixel_x:     pixel_x_i,
    pixel_y:     pixel_y_i,
    glyph_alpha: glyph_alpha_i
  };

  tcps_cfg_regs #(
    .MAX_CELL_WIDTH  (MAX_CELL_WIDTH),
    .MAX_CELL_HEIGHT (MAX_CELL_HEIGHT)
  ) u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tcps_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (item),
    .out_valid_o (dec_valid),
    .out_ready_i (dec_ready),
    .out_data_o  (dec_data)
  );

  tcps_shape u_shape (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (dec_valid),
    .in_ready_o  (dec_ready),
    .in_data_i   (dec_data),
    .out_valid_o (shp_valid),
    .out_ready_i (shp_ready),
    .out_data_o  (shp_data)
  );

  tcps_blend u_blend (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (shp_valid),
    .in_ready_o    (shp_ready),
    .in_data_i     (shp_data),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_color_o (pixel_color_o)
  );

endmodule

// ===== rtl/tcps_checker.sv =====
// ----------------------------------------------------------------------------
// tcps_checker: port-level checks for the pixel shader
// Watches the handshakes of the top level and is bound to it.
// ----------------------------------------------------------------------------
module tcps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [23:0] pixel_color_o
);

  // a result waiting for transfer keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_color_o))
    else $error("output changed while stalled");

  // with the sink ready the whole pipeline moves
  a_ready_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input blocked while output is ready");

  // input back-pressure only comes from a stalled result
  a_block_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input blocked without a pending result");

  // an unstalled transfer passes the decode, shape and blend registers to the output
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && out_ready_i) ##1 out_ready_i ##1 out_ready_i
    |=> out_valid_o)
    else $error("result missing after pipeline latency");

endmodule

bind terminal_cell_pixel_shader_unit tcps_checker u_tcps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .pixel_color_o (pixel_color_o)
);
